// File: rtl/irfse_pkg.sv
// Shared types and constants for the infrared frame symbol encoder.
`timescale 1ns / 1ps
`default_nettype none

package irfse_pkg;

  localparam int BYTE_W = 8;
  localparam int BT_W   = 13;
  localparam int TICK_W = 15;
  localparam int IDX_W  = 4;

  localparam logic [BT_W-1:0]   BIT_TICKS_RESET = 13'd200;
  localparam logic [IDX_W-1:0]  IDX_TAIL        = 4'd8;
  localparam logic [TICK_W-1:0] TICK_MAX        = 15'h7FFF;
  localparam logic [TICK_W-1:0] BIT_SPACE_TICKS = 15'd1;

  // One queued byte request with its precomputed frame checksum
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              first_byte;
    logic              last_byte;
    logic [BYTE_W-1:0] csum;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_CSUM
  } state_t;

endpackage

`default_nettype wire

// File: rtl/irfse_if.sv
// Handshake interfaces for byte requests and pulse symbols.
`timescale 1ns / 1ps
`default_nettype none

interface irfse_byte_if
  import irfse_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, output byte_value, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input byte_value, input first_byte, input last_byte,
                output ready);
endinterface

interface irfse_sym_if
  import irfse_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mark_level;
  logic [TICK_W-1:0] mark_ticks;
  logic              space_level;
  logic [TICK_W-1:0] space_ticks;
  logic              run_end;
  logic              frame_end;

  modport source (output valid, output mark_level, output mark_ticks, output space_level,
                  output space_ticks, output run_end, output frame_end, input ready);
  modport sink (input valid, input mark_level, input mark_ticks, input space_level,
                input space_ticks, input run_end, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/ir_frame_symbol_encoder.sv
// Top level of the infrared frame symbol encoder.
//
// Usage: byte requests enter on the bytes channel (valid/ready), each with
// first_byte and last_byte flags. Pulse symbols leave on the symbols channel,
// one symbol per request on that side. A byte yields 9 symbols (eight data
// bits LSB first plus a one-bit), 10 with first_byte (start symbol first),
// and 9 more with last_byte (checksum bits plus a closing zero-bit).
// The bit unit is set with cfg_we/cfg_wdata; write it only while idle.
// The first symbol of a byte is valid once it has passed the job queue,
// the sequencer state and the output register. Throughput: one symbol per
// cycle from the back-end sequencer unless the receiver stalls; a two-entry
// job queue lets the front accept bytes while the back end is still emitting.
// Reset clears the queue, the running sum, the sequencer and the output
// valid flag, and sets the bit unit to 200 ticks. When the receiver stalls,
// the output symbol holds, the sequencer pauses and the queue fills; then
// bytes.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module ir_frame_symbol_encoder
  import irfse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [BT_W-1:0] cfg_wdata,
  irfse_byte_if.sink           bytes,
  irfse_sym_if.source          symbols
);

  logic [BT_W-1:0] bit_ticks;
  job_t            q_job;
  logic            q_valid;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
    end else if (cfg_we) begin
      bit_ticks <= cfg_wdata;
    end
  end

  irfse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .q_job   (q_job),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  irfse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .bit_ticks (bit_ticks),
    .q_job     (q_job),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .symbols   (symbols)
  );

endmodule

`default_nettype wire

// File: rtl/irfse_front.sv
// Front end: accepts byte requests, keeps the running sum, queues jobs.
`timescale 1ns / 1ps
`default_nettype none

module irfse_front
  import irfse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  irfse_byte_if.sink bytes,
  output job_t       q_job,
  output logic       q_valid,
  input  wire logic  q_pop
);

  job_t              fifo_mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] sum_next;
  logic              push;

  assign bytes.ready = (count != 2'd2);
  assign push        = bytes.valid && bytes.ready;
  assign q_valid     = (count != 2'd0);
  assign q_job       = fifo_mem[rd_ptr];

  assign sum_next = (bytes.first_byte ? '0 : running_sum) + bytes.byte_value;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{byte_value: bytes.byte_value, first_byte: bytes.first_byte,
                            last_byte: bytes.last_byte, csum: sum_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= 1'b0;
      rd_ptr      <= 1'b0;
      count       <= 2'd0;
      running_sum <= '0;
    end else begin
      if (push) begin
        wr_ptr      <= ~wr_ptr;
        running_sum <= bytes.last_byte ? '0 : sum_next;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd2 && !q_pop) |=> (count == 2'd2))
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (rst)
                   (push && bytes.last_byte) |=> (running_sum == '0))
    else $error("sum not cleared after last byte");

endmodule

`default_nettype wire

// File: rtl/irfse_back.sv
// Back end: turns queued jobs into registered symbols, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module irfse_back
  import irfse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [BT_W-1:0] bit_ticks,
  input  job_t                 q_job,
  input  wire logic            q_valid,
  output logic                 q_pop,
  irfse_sym_if.source          symbols
);

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  job_t              job;
  logic              adv;
  logic              done;

  logic              sym_level;
  logic [TICK_W-1:0] sym_mark;
  logic [TICK_W-1:0] sym_space;
  logic              sym_run_end;
  logic              sym_frame_end;

  logic [TICK_W:0]   mark7;
  logic [TICK_W-1:0] start_mark;
  logic [TICK_W-1:0] bit_mark;

  logic              out_valid;
  logic              out_level;
  logic [TICK_W-1:0] out_mark;
  logic [TICK_W-1:0] out_space;
  logic              out_run_end;
  logic              out_frame_end;

  assign mark7      = {bit_ticks, 3'b000} - {3'b000, bit_ticks};
  assign start_mark = mark7[TICK_W] ? TICK_MAX : mark7[TICK_W-1:0];
  assign bit_mark   = (bit_ticks == '0) ? '0 : {2'b00, bit_ticks - 1'b1};

  assign adv = !out_valid || symbols.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    done          = 1'b0;
    sym_level     = 1'b0;
    sym_mark      = bit_mark;
    sym_space     = BIT_SPACE_TICKS;
    sym_run_end   = 1'b0;
    sym_frame_end = 1'b0;
    case (state)
      ST_IDLE: begin
        done = 1'b1;
      end
      ST_START: begin
        sym_level = 1'b1;
        sym_mark  = start_mark;
        sym_space = {2'b00, bit_ticks};
        if (adv) begin
          state_next = ST_DATA;
          idx_next   = '0;
        end
      end
      ST_DATA: begin
        sym_level   = (idx == IDX_TAIL) ? 1'b1 : job.byte_value[idx[2:0]];
        sym_run_end = (idx == IDX_TAIL) && !job.last_byte;
        if (adv) begin
          if (idx != IDX_TAIL) begin
            idx_next = idx + 1'b1;
          end else if (job.last_byte) begin
            state_next = ST_CSUM;
            idx_next   = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_CSUM: begin
        sym_level     = (idx == IDX_TAIL) ? 1'b0 : job.csum[idx[2:0]];
        sym_run_end   = (idx == IDX_TAIL);
        sym_frame_end = (idx == IDX_TAIL);
        if (adv) begin
          if (idx != IDX_TAIL) begin
            idx_next = idx + 1'b1;
          end else begin
            done = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    q_pop = done && q_valid;
    if (done) begin
      idx_next = '0;
      if (q_valid) begin
        state_next = q_job.first_byte ? ST_START : ST_DATA;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= (state != ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && state != ST_IDLE) begin
      out_level     <= sym_level;
      out_mark      <= sym_mark;
      out_space     <= sym_space;
      out_run_end   <= sym_run_end;
      out_frame_end <= sym_frame_end;
    end
  end

  assign symbols.valid       = out_valid;
  assign symbols.mark_level  = out_level;
  assign symbols.mark_ticks  = out_mark;
  assign symbols.space_level = 1'b0;
  assign symbols.space_ticks = out_space;
  assign symbols.run_end     = out_run_end;
  assign symbols.frame_end   = out_frame_end;

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_frame_end) |-> out_run_end)
    else $error("frame end without run end");
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_START && adv) |=> (state == ST_DATA && idx == '0))
    else $error("start symbol not followed by data bits");
  assert property (@(posedge clk) disable iff (rst)
                   (state != ST_IDLE) |-> (idx <= IDX_TAIL))
    else $error("bit index out of range");
  assert property (@(posedge clk) disable iff (rst)
                   (q_pop && state != ST_IDLE) |-> (adv && sym_run_end))
    else $error("new job taken before current one finished");

endmodule

`default_nettype wire

// File: dv/irfse_symbol_monitor.sv
// Predicts the pulse symbols of each byte request and compares them with the encoder output.
`timescale 1ns / 1ps

module irfse_symbol_monitor
  import irfse_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [BT_W-1:0] cfg_wdata,
  irfse_byte_if           bytes,
  irfse_sym_if            symbols,
  output int              mismatch_count,
  output int              symbols_outstanding
);

  typedef struct packed {
    logic              mark_level;
    logic [TICK_W-1:0] mark_ticks;
    logic              space_level;
    logic [TICK_W-1:0] space_ticks;
    logic              run_end;
    logic              frame_end;
  } symbol_t;

  logic [BT_W-1:0]   unit_ticks;
  logic [BYTE_W-1:0] frame_sum;
  symbol_t           expected_symbols[$];
  int                errors;

  function automatic logic [TICK_W-1:0] clip_ticks(int unsigned t);
    return (t > TICK_MAX) ? TICK_MAX : t[TICK_W-1:0];
  endfunction

  function automatic void push_symbol(logic lvl, int unsigned mark, int unsigned space);
    symbol_t s;
    s = '0;
    s.mark_level  = lvl;
    s.mark_ticks  = clip_ticks(mark);
    s.space_ticks = clip_ticks(space);
    expected_symbols.push_back(s);
  endfunction

  function automatic void push_bit(logic lvl);
    int unsigned mark;
    mark = (unit_ticks > 0) ? int'(unit_ticks) - 1 : 0;
    push_symbol(lvl, mark, BIT_SPACE_TICKS);
  endfunction

  // eight data bits LSB first, then the tail bit
  function automatic void push_byte(logic [BYTE_W-1:0] value, logic tail);
    for (int i = 0; i < BYTE_W; i++) begin
      push_bit(value[i]);
    end
    push_bit(tail);
  endfunction

  function automatic void predict_request(logic [BYTE_W-1:0] value, logic first, logic last);
    if (first) begin
      push_symbol(1'b1, int'(unit_ticks) * 7, unit_ticks);
      frame_sum = '0;
    end
    frame_sum = frame_sum + value;
    push_byte(value, 1'b1);
    if (last) begin
      push_byte(frame_sum, 1'b0);
      expected_symbols[expected_symbols.size()-1].frame_end = 1'b1;
      frame_sum = '0;
    end
    expected_symbols[expected_symbols.size()-1].run_end = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : track
    symbol_t want;
    if (rst) begin
      unit_ticks = BIT_TICKS_RESET;
      frame_sum  = '0;
      expected_symbols.delete();
      errors     = 0;
    end else begin
      if (cfg_we) begin
        unit_ticks = cfg_wdata;
      end
      if (bytes.valid && bytes.ready) begin
        predict_request(bytes.byte_value, bytes.first_byte, bytes.last_byte);
      end
      if (symbols.valid && symbols.ready) begin
        if (expected_symbols.size() == 0) begin
          $error("unexpected symbol: mark_level %0d mark_ticks %0d space_ticks %0d",
                 symbols.mark_level, symbols.mark_ticks, symbols.space_ticks);
          errors++;
        end else begin
          want = expected_symbols.pop_front();
          check_field("mark_level", want.mark_level, symbols.mark_level);
          check_field("mark_ticks", want.mark_ticks, symbols.mark_ticks);
          check_field("space_level", want.space_level, symbols.space_level);
          check_field("space_ticks", want.space_ticks, symbols.space_ticks);
          check_field("run_end", want.run_end, symbols.run_end);
          check_field("frame_end", want.frame_end, symbols.frame_end);
        end
      end
    end
    mismatch_count      <= errors;
    symbols_outstanding <= expected_symbols.size();
  end

endmodule

// File: dv/ir_frame_symbol_encoder_tb.sv
// Testbench top: drives byte requests and bit-unit settings into the encoder and gives the verdict.
`timescale 1ns / 1ps

module ir_frame_symbol_encoder_tb;
  import irfse_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 57;
  localparam int NUM_PHASES   = 6;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [BT_W-1:0] cfg_wdata;
  int              idle_pct = 37;
  int              stall_cycles;
  int              mismatch_count;
  int              symbols_outstanding;

  irfse_byte_if bytes_ch ();
  irfse_sym_if  sym_ch ();

  ir_frame_symbol_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bytes     (bytes_ch),
    .symbols   (sym_ch)
  );

  irfse_symbol_monitor u_symbol_monitor (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .bytes               (bytes_ch),
    .symbols             (sym_ch),
    .mismatch_count      (mismatch_count),
    .symbols_outstanding (symbols_outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      sym_ch.ready <= 1'b0;
    end else begin
      sym_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (sym_ch.valid && sym_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(logic [BYTE_W-1:0] value, logic first, logic last);
    while ($urandom_range(99) < idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid      <= 1'b1;
    bytes_ch.byte_value <= value;
    bytes_ch.first_byte <= first;
    bytes_ch.last_byte  <= last;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (symbols_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bit_ticks(logic [BT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed frames, some requests with random flags
  task automatic run_random(int n_items);
    int sent;
    int frame_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_request($urandom_range(255), $urandom_range(1), $urandom_range(1));
        sent++;
      end else begin
        frame_len = ($urandom_range(3) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
        for (int i = 0; i < frame_len; i++) begin
          send_request($urandom_range(255), i == 0, i == frame_len - 1);
        end
        sent += frame_len;
      end
    end
  endtask

  initial begin
    logic [BT_W-1:0] unit_settings[NUM_PHASES];
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    bytes_ch.valid      = 1'b0;
    bytes_ch.byte_value = '0;
    bytes_ch.first_byte = 1'b0;
    bytes_ch.last_byte  = 1'b0;
    unit_settings       = '{13'd2, 13'd4681, 13'd4095, 13'd0, 13'd3, BIT_TICKS_RESET};
    unit_settings[3]    = $urandom_range(4681, 2);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes before any frame opened
    send_request(8'h81, 1'b0, 1'b0);
    send_request(8'h7E, 1'b0, 1'b1);
    // first and last together
    send_request(8'h00, 1'b1, 1'b1);
    // checksum wraps
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    // restart inside an open frame
    send_request(8'h12, 1'b1, 1'b0);
    send_request(8'h34, 1'b0, 1'b0);
    send_request(8'h56, 1'b1, 1'b0);
    send_request(8'h78, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    wait_idle();
    write_bit_ticks(13'd2);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'h80, 1'b0, 1'b1);
    wait_idle();
    write_bit_ticks(13'd4681);
    send_request(8'hC3, 1'b1, 1'b1);
    send_request(8'h3C, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_bit_ticks(unit_settings[p]);
      idle_pct = (p == 2) ? 0 : 37;
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: ir_frame_symbol_encoder.f
rtl/irfse_pkg.sv
rtl/irfse_if.sv
rtl/irfse_front.sv
rtl/irfse_back.sv
rtl/ir_frame_symbol_encoder.sv
dv/irfse_symbol_monitor.sv
dv/ir_frame_symbol_encoder_tb.sv
